[design/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // default sizing
    localparam int MAX_WORDS_DEF   = 1024;
    localparam int FRAME_SHIFT_DEF = 12;

    // bitmap word geometry
    localparam int          WORD_BITS = 32;
    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [10:0] BITMAP_WORDS_RST    = 11'd1024;
    localparam logic [15:0] RESERVED_FRAMES_RST = 16'd1024;

    // configuration register indexes
    localparam logic [1:0] REG_BITMAP_WORDS    = 2'd0;
    localparam logic [1:0] REG_RESERVED_FRAMES = 2'd1;

    // action codes
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_NOMEM = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } t_state;

endpackage

[design/bfa_ram.sv]
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bitmap_frame_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// Page-frame allocator over a used-frame bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per beat: tuser is the action (initialize,
//   allocate, mark used), tdata the physical address for mark used.
//   m_axis returns one response per request: tdata the allocated frame
//   address (zero otherwise), tuser the status.
//   cfg writes (always ready) set the word count and the reserved frame count;
//   the user must write them only while the block is idle (not enforced).
// Sequence (one bitmap word is read or written per cycle on the single RAM):
//   initialize: each word in use is written in turn, then the response
//   allocate:   each word is read, then checked, until one has a free bit
//   mark used:  the word is read, then written; a range error goes straight
//   to the response, which enters the output register once that is free.
// Reset: a clearing pass zeroes all MAX_WORDS words, one per cycle;
//   s_axis_tready stays low meanwhile.
// Stall: a new request is taken while a response waits in the output
//   register; the following response is held until m_axis_tready frees it.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit
    import bfa_pkg::*;
#(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] phys_addr
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // response stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] frame_address
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW   = $clog2(MAX_WORDS + 1);
    localparam int FRW  = AW + 5;
    localparam int WW   = (CW > 11) ? CW : 11;
    localparam int CMPW = ((32 - FRAME_SHIFT) > (CW + 5)) ? (32 - FRAME_SHIFT) : (CW + 5);

    // lowest set bit of a nonzero word, binary search
    function automatic logic [4:0] low_one(input logic [31:0] v);
        logic [4:0]  n;
        logic [31:0] x;
        n = 5'd0;
        x = v;
        if (x[15:0] == 16'd0) begin
            n[4] = 1'b1;
            x = x >> 16;
        end
        if (x[7:0] == 8'd0) begin
            n[3] = 1'b1;
            x = x >> 8;
        end
        if (x[3:0] == 4'd0) begin
            n[2] = 1'b1;
            x = x >> 4;
        end
        if (x[1:0] == 2'd0) begin
            n[1] = 1'b1;
            x = x >> 2;
        end
        if (x[0] == 1'b0) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    t_state r_state, n_state;

    logic [10:0]     r_bitmap_words;
    logic [15:0]     r_reserved;
    logic [CW-1:0]   r_idx, n_idx;
    logic [15:0]     r_rem, n_rem;
    logic [FRW-1:0]  r_frame, n_frame;
    logic [31:0]     r_res_addr, n_res_addr;
    logic [1:0]      r_res_sts, n_res_sts;
    logic            r_m_valid;
    logic [31:0]     r_m_data;
    logic [1:0]      r_m_user;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic            in_fire;
    logic            resp_load;
    logic [WW-1:0]   bw_ext;
    logic [CW-1:0]   eff_words;
    logic [CMPW-1:0] frames_in_use;
    logic [CMPW-1:0] req_frame;
    logic [CMPW-1:0] res_ext;
    logic [CMPW-1:0] init_count;
    logic            range_err;
    logic            word_full;
    logic            last_word;
    logic [4:0]      free_bit;
    logic [63:0]     faddr_wide;
    logic [31:0]     init_word;

    // bitmap storage
    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign resp_load     = (r_state == ST_RESP) && (!r_m_valid || m_axis_tready);

    // sizing from configuration
    assign bw_ext        = WW'(r_bitmap_words);
    assign eff_words     = (bw_ext > WW'(MAX_WORDS)) ? CW'(MAX_WORDS) : CW'(r_bitmap_words);
    assign frames_in_use = CMPW'(eff_words) << 5;
    assign req_frame     = CMPW'(s_axis_tdata >> FRAME_SHIFT);
    assign range_err     = (req_frame >= frames_in_use);
    assign res_ext       = CMPW'(r_reserved);
    assign init_count    = (res_ext < frames_in_use) ? res_ext : frames_in_use;

    // scan helpers
    assign last_word  = ((r_idx + 1'b1) == eff_words);
    assign word_full  = (ram_rdata == FULL_WORD);
    assign free_bit   = low_one(~ram_rdata);
    assign faddr_wide = 64'({r_idx[AW-1:0], free_bit}) << FRAME_SHIFT;
    assign init_word  = (r_rem >= 16'(WORD_BITS)) ? FULL_WORD
                      : ((32'h1 << r_rem[4:0]) - 32'h1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == CW'(MAX_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        ACT_INIT:  n_state = (eff_words == '0) ? ST_RESP : ST_INIT;
                        ACT_ALLOC: n_state = (eff_words == '0) ? ST_RESP : ST_ALLOC_RD;
                        ACT_MARK:  n_state = range_err ? ST_RESP : ST_MARK_RD;
                        default:   n_state = ST_RESP;
                    endcase
                end
            end
            ST_INIT: begin
                if (last_word) begin
                    n_state = ST_RESP;
                end
            end
            ST_ALLOC_RD:  n_state = ST_ALLOC_CHK;
            ST_ALLOC_CHK: begin
                if (!word_full || last_word) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_ALLOC_RD;
                end
            end
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: n_state = ST_RESP;
            ST_RESP: begin
                if (resp_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_idx      = r_idx;
        n_rem      = r_rem;
        n_frame    = r_frame;
        n_res_addr = r_res_addr;
        n_res_sts  = r_res_sts;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = 32'd0;
        ram_re     = 1'b0;
        ram_raddr  = r_idx[AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + 1'b1;
            end
            ST_IDLE: begin
                n_idx      = '0;
                n_rem      = 16'(init_count);
                n_frame    = req_frame[FRW-1:0];
                n_res_addr = 32'd0;
                n_res_sts  = STS_OK;
                if (s_axis_tuser == ACT_ALLOC && eff_words == '0) begin
                    n_res_sts = STS_NOMEM;
                end
                if (s_axis_tuser == ACT_MARK && range_err) begin
                    n_res_sts = STS_RANGE;
                end
            end
            ST_INIT: begin
                // each word gets the reserved bits that fall in it
                ram_we    = 1'b1;
                ram_wdata = init_word;
                n_idx     = r_idx + 1'b1;
                n_rem     = (r_rem >= 16'(WORD_BITS)) ? (r_rem - 16'(WORD_BITS)) : 16'd0;
            end
            ST_ALLOC_RD: begin
                ram_re = 1'b1;
            end
            ST_ALLOC_CHK: begin
                if (!word_full) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | (32'h1 << free_bit);
                    n_res_addr = faddr_wide[31:0];
                end else if (last_word) begin
                    n_res_sts = STS_NOMEM;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MARK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_frame[FRW-1:5];
            end
            ST_MARK_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_frame[FRW-1:5];
                ram_wdata = ram_rdata | (32'h1 << r_frame[4:0]);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_idx          <= '0;
            r_bitmap_words <= BITMAP_WORDS_RST;
            r_reserved     <= RESERVED_FRAMES_RST;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_BITMAP_WORDS) begin
                    r_bitmap_words <= i_cfg_data[10:0];
                end else if (i_cfg_index == REG_RESERVED_FRAMES) begin
                    r_reserved <= i_cfg_data;
                end
            end
            if (resp_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_frame    <= n_frame;
        r_res_addr <= n_res_addr;
        r_res_sts  <= n_res_sts;
        if (resp_load) begin
            r_m_data <= r_res_addr;
            r_m_user <= r_res_sts;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule
